FILE: rtl/core/u8u16_pkg.sv
`default_nettype none
package u8u16_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned UNIT_W   = 16;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned PEND_W   = 2;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned OUT_TUSER_W = 2;

    localparam logic [COUNT_W-1:0] MAX_CHARS_RESET = 7'd126;

    // lead and continuation byte prefixes
    localparam logic [2:0] LEAD2_PFX = 3'b110;
    localparam logic [3:0] LEAD3_PFX = 4'b1110;
    localparam logic [1:0] CONT_PFX  = 2'b10;
    // top five bits of a surrogate value
    localparam logic [4:0] SURR_PFX  = 5'b11011;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_string;
    } t_item;

    typedef struct packed {
        logic [UNIT_W-1:0]  code_unit;
        logic               unit_valid;
        logic               done_res;
        logic               error;
        logic [COUNT_W-1:0] char_count;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/core/u8u16_in_stage.sv
`default_nettype none
module u8u16_in_stage (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    input  wire logic [u8u16_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input  wire logic                                i_s_axis_tlast,
    input  wire logic                                i_advance,
    output logic                                     o_valid,
    output u8u16_pkg::t_item                         o_item
);
    import u8u16_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;
    logic  w_take;

    assign o_s_axis_tready = !r_valid || i_advance;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (w_take) begin
            r_item.data_byte     <= i_s_axis_tdata[BYTE_W-1:0];
            r_item.end_of_string <= i_s_axis_tlast;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

FILE: rtl/core/u8u16_decode.sv
`default_nettype none
module u8u16_decode (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_advance,
    input  wire u8u16_pkg::t_item                  i_item,
    input  wire logic [u8u16_pkg::COUNT_W-1:0]     i_max_chars,
    output logic                                   o_emit,
    output u8u16_pkg::t_result                     o_result
);
    import u8u16_pkg::*;

    logic [UNIT_W-1:0]  r_partial;
    logic [PEND_W-1:0]  r_pend;
    logic [COUNT_W-1:0] r_count;
    logic               r_stopped;
    logic               r_failed;

    logic [UNIT_W-1:0]  n_partial;
    logic [PEND_W-1:0]  n_pend;
    logic [COUNT_W-1:0] n_count;
    logic               n_stopped;
    logic               n_failed;

    logic [BYTE_W-1:0]  w_b;
    logic [UNIT_W-1:0]  w_v;
    logic [UNIT_W-1:0]  w_unit;
    logic               w_have;
    logic               w_abort;

    assign w_b = i_item.data_byte;
    assign w_v = r_partial | {10'd0, w_b[5:0]};

    always_comb begin
        n_partial = r_partial;
        n_pend    = r_pend;
        n_stopped = r_stopped;
        n_failed  = r_failed;
        w_have    = 1'b0;
        w_unit    = '0;
        w_abort   = 1'b0;
        if (!r_stopped) begin
            if (r_pend == PEND_NONE) begin
                if (r_count >= i_max_chars || w_b == '0) begin
                    n_stopped = 1'b1;
                end else if (!w_b[7]) begin
                    w_unit = {8'd0, w_b};
                    w_have = 1'b1;
                end else if (w_b[7:5] == LEAD2_PFX) begin
                    n_partial = {5'd0, w_b[4:0], 6'd0};
                    n_pend    = PEND_ONE;
                end else if (w_b[7:4] == LEAD3_PFX) begin
                    n_partial = {w_b[3:0], 12'd0};
                    n_pend    = PEND_TWO;
                end else begin
                    w_abort = 1'b1;
                end
            end else if (w_b[7:6] != CONT_PFX) begin
                w_abort = 1'b1;
            end else if (r_pend == PEND_TWO) begin
                n_partial = r_partial | {4'd0, w_b[5:0], 6'd0};
                n_pend    = PEND_ONE;
            end else begin
                n_pend    = PEND_NONE;
                n_partial = '0;
                if (w_v[15:11] == SURR_PFX) begin
                    w_abort = 1'b1;
                end else begin
                    w_unit = w_v;
                    w_have = 1'b1;
                end
            end
        end
        if (w_abort) begin
            n_failed  = 1'b1;
            n_stopped = 1'b1;
            n_pend    = PEND_NONE;
            n_partial = '0;
        end
        n_count = w_have ? r_count + 1'b1 : r_count;

        o_result.code_unit  = w_unit;
        o_result.unit_valid = w_have;
        o_result.done_res   = i_item.end_of_string;
        o_result.error      = i_item.end_of_string
                              && (n_failed || (!n_stopped && n_pend != PEND_NONE));
        o_result.char_count = n_count;
        o_emit              = w_have || i_item.end_of_string;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pend    <= PEND_NONE;
            r_count   <= '0;
            r_stopped <= 1'b0;
            r_failed  <= 1'b0;
        end else if (i_advance) begin
            if (i_item.end_of_string) begin
                r_partial <= '0;
                r_pend    <= PEND_NONE;
                r_count   <= '0;
                r_stopped <= 1'b0;
                r_failed  <= 1'b0;
            end else begin
                r_partial <= n_partial;
                r_pend    <= n_pend;
                r_count   <= n_count;
                r_stopped <= n_stopped;
                r_failed  <= n_failed;
            end
        end
    end

`ifndef ASSERT_OFF
    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'b11)
        else $error("pending count out of range");
    a_failed_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> r_stopped)
        else $error("error without stop");
    a_stopped_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_pend == PEND_NONE && r_partial == '0))
        else $error("open sequence while stopped");
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_item.end_of_string) |=> (r_count == '0 && !r_stopped))
        else $error("string state not cleared after last byte");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/u8u16_out_stage.sv
`default_nettype none
module u8u16_out_stage (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_advance,
    input  wire logic                                 i_emit,
    input  wire u8u16_pkg::t_result                   i_result,
    output logic                                      o_can_load,
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    output logic [u8u16_pkg::OUT_TDATA_W-1:0]         o_m_axis_tdata,
    output logic [u8u16_pkg::OUT_TUSER_W-1:0]         o_m_axis_tuser,
    output logic                                      o_m_axis_tlast
);
    import u8u16_pkg::*;

    logic    r_valid;
    t_result r_result;
    logic    n_valid;

    assign o_can_load = !r_valid || i_m_axis_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_advance) begin
            n_valid = i_emit;
        end else if (i_m_axis_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_advance && i_emit) begin
            r_result <= i_result;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {1'b0, r_result.char_count, r_result.code_unit};
    assign o_m_axis_tuser  = {r_result.error, r_result.unit_valid};
    assign o_m_axis_tlast  = r_result.done_res;

endmodule
`default_nettype wire

FILE: rtl/core/utf8_to_utf16le_converter_core.sv
// channel   dir  handshake                  payload
// s_axis    in   tvalid / tready            tdata[7:0] data_byte, tlast end_of_string
// m_axis    out  tvalid / tready            tdata code_unit, char_count; tuser; tlast done_res
// cfg       in   i_cfg_we (no wait)         i_cfg_wdata[6:0] max_chars
//
// one byte per cycle sustained while m_axis does not stall; input register, then decode into the result register
// reset: synchronous active low, clears string state, max_chars returns to 126
// a byte that completes no character and is not the last gives no result
// output stall holds the decode stage; the input register then fills and drops tready
`default_nettype none
module utf8_to_utf16le_converter_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // [7:0] data_byte
    input  wire logic [u8u16_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input  wire logic                                i_s_axis_tlast,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // [15:0] code_unit, [22:16] char_count, [23] zero
    output logic [u8u16_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    // [0] unit_valid, [1] error
    output logic [u8u16_pkg::OUT_TUSER_W-1:0]        o_m_axis_tuser,
    output logic                                     o_m_axis_tlast,
    input  wire logic                                i_cfg_we,
    input  wire logic [u8u16_pkg::COUNT_W-1:0]       i_cfg_wdata
);
    import u8u16_pkg::*;

    logic [COUNT_W-1:0] r_max_chars;
    logic               w_in_valid;
    t_item              w_item;
    logic               w_can_load;
    logic               w_advance;
    logic               w_emit;
    t_result            w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars <= MAX_CHARS_RESET;
        end else if (i_cfg_we) begin
            r_max_chars <= i_cfg_wdata;
        end
    end

    assign w_advance = w_in_valid && w_can_load;

    u8u16_in_stage u_in (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_advance       (w_advance),
        .o_valid         (w_in_valid),
        .o_item          (w_item)
    );

    u8u16_decode u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_item      (w_item),
        .i_max_chars (r_max_chars),
        .o_emit      (w_emit),
        .o_result    (w_result)
    );

    u8u16_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (w_advance),
        .i_emit          (w_emit),
        .i_result        (w_result),
        .o_can_load      (w_can_load),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

`ifndef ASSERT_OFF
    a_err_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> o_m_axis_tlast)
        else $error("error flag without done");
    a_unit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata[15:0] == '0))
        else $error("code unit set without a character");
    a_no_surrogate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata[15:11] != SURR_PFX))
        else $error("surrogate value emitted");
`endif

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import u8u16_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic       typed;
        t_result    res;
    } t_dir_row;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_valid   = 1'b0;
    logic [7:0]  s_data    = 8'h00;
    logic        s_last    = 1'b0;
    logic        m_ready   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [6:0]  cfg_wdata = 7'd0;

    logic        s_ready;
    logic        m_valid;
    logic [23:0] m_data;
    logic [1:0]  m_user;
    logic        m_last;

    // decoder state mirrored by the testbench
    logic [15:0] acc    = 16'h0000;
    logic [1:0]  pend   = PEND_NONE;
    logic [6:0]  nconv  = 7'd0;
    logic        halt   = 1'b0;
    logic        failed = 1'b0;
    logic [6:0]  cap    = MAX_CHARS_RESET;

    t_result     units_due [$];
    logic [7:0]  str_bytes [$];
    bit          quiet = 1'b0;
    int unsigned errs  = 0;
    int unsigned n_res = 0;

    utf8_to_utf16le_converter_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #10 clk = ~clk;

    task automatic log_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errs++;
    endtask

    function automatic bit decode_byte(input logic [7:0] b, input logic eos,
                                       output t_result r);
        logic [15:0] v;
        logic        got;
        logic        bad;
        got = 1'b0;
        bad = 1'b0;
        v   = 16'h0000;
        r   = '0;
        if (!halt) begin
            if (pend == PEND_NONE) begin
                if (nconv >= cap || b == 8'h00) begin
                    halt = 1'b1;
                end else if (!b[7]) begin
                    v   = {8'h00, b};
                    got = 1'b1;
                end else if (b[7:5] == LEAD2_PFX) begin
                    acc  = {5'd0, b[4:0], 6'd0};
                    pend = PEND_ONE;
                end else if (b[7:4] == LEAD3_PFX) begin
                    acc  = {b[3:0], 12'd0};
                    pend = PEND_TWO;
                end else begin
                    bad = 1'b1;
                end
            end else if (b[7:6] != CONT_PFX) begin
                bad = 1'b1;
            end else if (pend == PEND_TWO) begin
                acc[11:6] = b[5:0];
                pend      = PEND_ONE;
            end else begin
                v    = acc | {10'd0, b[5:0]};
                pend = PEND_NONE;
                acc  = 16'h0000;
                // surrogate halves are not characters
                if (v[15:11] == SURR_PFX) begin
                    bad = 1'b1;
                end else begin
                    got = 1'b1;
                end
            end
            if (bad) begin
                failed = 1'b1;
                halt   = 1'b1;
                pend   = PEND_NONE;
                acc    = 16'h0000;
            end
            if (got) begin
                nconv = nconv + 7'd1;
            end
        end
        r.code_unit  = got ? v : 16'h0000;
        r.unit_valid = got;
        r.done_res   = eos;
        r.error      = eos && (failed || (!halt && pend != PEND_NONE));
        r.char_count = nconv;
        if (eos) begin
            acc    = 16'h0000;
            pend   = PEND_NONE;
            nconv  = 7'd0;
            halt   = 1'b0;
            failed = 1'b0;
        end
        return got || eos;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eos);
        while (!quiet && $urandom_range(0, 99) < 32) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= eos;
        do @(negedge clk); while (!s_ready);
        @(posedge clk);
    endtask

    task automatic send_string();
        t_result r;
        int unsigned i;
        for (i = 0; i < str_bytes.size(); i++) begin
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
            if (decode_byte(str_bytes[i], i == str_bytes.size() - 1, r)) begin
                units_due.push_back(r);
            end
        end
    endtask

    task automatic build_string(input bit long_one);
        int unsigned n;
        int unsigned i;
        int unsigned pick;
        str_bytes.delete();
        n = long_one ? 130 : $urandom_range(1, 8);
        for (i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (long_one || pick < 45) begin
                str_bytes.push_back(8'($urandom_range(1, 127)));
            end else if (pick < 65) begin
                str_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                str_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
            end else if (pick < 85) begin
                str_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                str_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
                str_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
            end else if (pick < 92) begin
                str_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 95) begin
                str_bytes.push_back(8'h00);
            end else begin
                // truncated three-byte sequence
                str_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                if ($urandom_range(0, 1) == 1) begin
                    str_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
                end
            end
        end
    endtask

    task automatic write_cap(input logic [6:0] v);
        s_valid <= 1'b0;
        while (units_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cap = v;
    endtask

    always @(posedge clk) begin
        m_ready <= quiet || ($urandom_range(0, 99) >= 32);
    end

    // outputs are stable at the falling edge; a transaction completes at the next rising edge
    always @(negedge clk) begin
        t_result got;
        t_result want;
        if (rst_n && m_valid && m_ready) begin
            got.code_unit  = m_data[15:0];
            got.char_count = m_data[22:16];
            got.unit_valid = m_user[0];
            got.error      = m_user[1];
            got.done_res   = m_last;
            if (units_due.size() == 0) begin
                log_mismatch($sformatf("unexpected result unit %h count %0d",
                                       got.code_unit, got.char_count));
            end else begin
                want = units_due.pop_front();
                if (got.code_unit !== want.code_unit || got.unit_valid !== want.unit_valid ||
                    got.done_res !== want.done_res || got.error !== want.error ||
                    got.char_count !== want.char_count) begin
                    log_mismatch($sformatf(
                        "result %0d got %h/v%b/d%b/e%b/n%0d want %h/v%b/d%b/e%b/n%0d",
                        n_res, got.code_unit, got.unit_valid, got.done_res, got.error,
                        got.char_count, want.code_unit, want.unit_valid, want.done_res,
                        want.error, want.char_count));
                end
            end
            n_res++;
        end
    end

    initial begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_dir_row    dir_rows [25];
        t_result     r;
        int unsigned k;
        int unsigned ph;
        int unsigned sent;
        logic [6:0]  cap_v;

        // data, eos, typed, code_unit, unit_valid, done, error, char_count
        dir_rows[0]  = {8'h41, 1'b0, 1'b1, 16'h0041, 1'b1, 1'b0, 1'b0, 7'd1};
        dir_rows[1]  = {8'h7F, 1'b0, 1'b1, 16'h007F, 1'b1, 1'b0, 1'b0, 7'd2};
        dir_rows[2]  = {8'hC2, 1'b0, 1'b0, 26'd0};
        dir_rows[3]  = {8'hA9, 1'b0, 1'b0, 26'd0};
        dir_rows[4]  = {8'hE2, 1'b0, 1'b0, 26'd0};
        dir_rows[5]  = {8'h82, 1'b0, 1'b0, 26'd0};
        dir_rows[6]  = {8'hAC, 1'b0, 1'b0, 26'd0};
        dir_rows[7]  = {8'hEF, 1'b0, 1'b0, 26'd0};
        dir_rows[8]  = {8'hBF, 1'b0, 1'b0, 26'd0};
        dir_rows[9]  = {8'hBF, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b0, 7'd5};
        // overlong zero, then a surrogate; then a lone 0xFF byte
        dir_rows[10] = {8'hC0, 1'b0, 1'b0, 26'd0};
        dir_rows[11] = {8'h80, 1'b0, 1'b0, 26'd0};
        dir_rows[12] = {8'hED, 1'b0, 1'b0, 26'd0};
        dir_rows[13] = {8'hA0, 1'b0, 1'b0, 26'd0};
        dir_rows[14] = {8'h80, 1'b0, 1'b0, 26'd0};
        dir_rows[15] = {8'h41, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1, 7'd1};
        dir_rows[16] = {8'hFF, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1, 7'd0};
        // stray continuation
        dir_rows[17] = {8'h80, 1'b0, 1'b0, 26'd0};
        dir_rows[18] = {8'h41, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1, 7'd0};
        // zero byte ends conversion cleanly
        dir_rows[19] = {8'h00, 1'b0, 1'b0, 26'd0};
        dir_rows[20] = {8'h41, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b0, 7'd0};
        // zero byte as continuation
        dir_rows[21] = {8'hC3, 1'b0, 1'b0, 26'd0};
        dir_rows[22] = {8'h00, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1, 7'd0};
        // sequence open at end of string
        dir_rows[23] = {8'hE1, 1'b0, 1'b0, 26'd0};
        dir_rows[24] = {8'h80, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1, 7'd0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < 25; k++) begin
            send_byte(dir_rows[k].data, dir_rows[k].eos);
            if (decode_byte(dir_rows[k].data, dir_rows[k].eos, r) && !dir_rows[k].typed) begin
                units_due.push_back(r);
            end
            if (dir_rows[k].typed) begin
                units_due.push_back(dir_rows[k].res);
            end
        end

        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                0:       cap_v = 7'd1;
                1:       cap_v = 7'd126;
                2:       cap_v = 7'd2;
                4:       cap_v = 7'($urandom_range(1, 5));
                5:       cap_v = 7'd126;
                default: cap_v = 7'($urandom_range(1, 126));
            endcase
            quiet = (ph == 1);
            write_cap(cap_v);
            sent = 0;
            if (ph == 5) begin
                build_string(1'b1);
                send_string();
                sent += str_bytes.size();
            end
            while (sent < 75) begin
                build_string(1'b0);
                send_string();
                sent += str_bytes.size();
            end
        end

        s_valid <= 1'b0;
        while (units_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (errs == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
